// ===== src/crcfr_pkg.sv =====
// Package with the types, codes and CRC function of the frame receiver.
package crcfr_pkg;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_HDR  = 6'b000010,
    PH_PAY  = 6'b000100,
    PH_CRCH = 6'b001000,
    PH_CRCL = 6'b010000,
    PH_SKIP = 6'b100000
  } phase_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSYNC  = 3'd1;
  localparam logic [2:0] ST_TOOLONG = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_BADCRC  = 3'd4;

  localparam int unsigned REG_ADDR_W = 4;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_PREAMBLE = 2'd0;
  localparam reg_index_t REG_START    = 2'd1;
  localparam reg_index_t REG_LIMIT    = 2'd2;

  localparam logic [7:0] PREAMBLE_RESET = 8'h55;
  localparam logic [7:0] START_RESET    = 8'hD5;
  localparam logic [7:0] LIMIT_RESET    = 8'hFF;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic [2:0] status;
    logic [7:0] length;
    logic [7:0] source;
    logic [7:0] dest;
    logic [7:0] fkind;
  } result_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/crc_frame_receiver_unit.sv =====
// Top level of the byte-serial frame receiver with CRC-16 check.
//
// Raw bytes of a buffer enter on the byte channel (byte_valid, byte_stall), one byte per
// cycle while byte_stall is low, the last byte of a buffer marked by end_of_buffer.
// After a preamble byte directly followed by the start byte, the block takes length,
// source, destination and type, passes each payload byte on as a provisional result
// word, and ends every buffer with one status word that carries the header and the
// outcome of the CRC-16 check. The result receiver is to drop the payload of a frame
// whose status is not ok; the block does not. A byte is processed in the cycle it is
// accepted and its result is registered; one byte per cycle is sustained, limited only
// by the result receiver. While result_stall is high the output register holds its word
// and a one-word skid register absorbs the next result; byte_stall rises only when that
// skid register is full. Reset clears the valid flags of the output and skid registers,
// returns the deframer to hunting for a start byte and loads the register defaults.
// Registers are written through the APB-style port at byte addresses 0, 4 and 8.
module crc_frame_receiver_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [crcfr_pkg::REG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                byte_valid,
  output logic                                byte_stall,
  input  logic [7:0]                          raw_byte,
  input  logic                                end_of_buffer,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                result_kind,
  output logic [7:0]                          payload_byte,
  output logic [2:0]                          frame_status,
  output logic [7:0]                          frame_length,
  output logic [7:0]                          source_id,
  output logic [7:0]                          dest_id,
  output logic [7:0]                          frame_kind
);
  import crcfr_pkg::*;

  logic [7:0] preamble_value;
  logic [7:0] start_value;
  logic [7:0] payload_limit;

  phase_t      phase, phase_next;
  logic [7:0]  previous_byte, previous_byte_next;
  logic        previous_valid, previous_valid_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  length_held, length_held_next;
  logic [7:0]  source_held, source_held_next;
  logic [7:0]  dest_held, dest_held_next;
  logic [7:0]  kind_held, kind_held_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  crc_high_held, crc_high_held_next;

  result_t     out_word, skid_word, new_word;
  logic        skid_valid;
  logic        new_valid;
  logic        accept;
  logic        cfg_write;
  reg_index_t  reg_index;
  logic [15:0] crc_after;
  logic [7:0]  count_inc;
  logic        restart;

  assign pready    = 1'b1;
  assign reg_index = paddr[REG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_value <= PREAMBLE_RESET;
      start_value    <= START_RESET;
      payload_limit  <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        REG_PREAMBLE: preamble_value <= pwdata[7:0];
        REG_START:    start_value    <= pwdata[7:0];
        REG_LIMIT:    payload_limit  <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_PREAMBLE: prdata = {24'd0, preamble_value};
      REG_START:    prdata = {24'd0, start_value};
      REG_LIMIT:    prdata = {24'd0, payload_limit};
      default:      prdata = 32'd0;
    endcase
  end

  assign byte_stall = skid_valid;
  assign accept     = byte_valid && !byte_stall;
  assign crc_after  = crc_step(running_crc, raw_byte);
  assign count_inc  = byte_count + 8'd1;

  always_comb begin
    phase_next          = phase;
    previous_byte_next  = previous_byte;
    previous_valid_next = previous_valid;
    running_crc_next    = running_crc;
    length_held_next    = length_held;
    source_held_next    = source_held;
    dest_held_next      = dest_held;
    kind_held_next      = kind_held;
    byte_count_next     = byte_count;
    crc_high_held_next  = crc_high_held;
    restart             = 1'b0;
    new_valid           = 1'b0;
    new_word            = '0;
    new_word.kind       = 1'b1;

    case (phase)
      PH_HUNT: begin
        if (end_of_buffer) begin
          new_valid     = 1'b1;
          new_word.status = ST_NOSYNC;
          restart       = 1'b1;
        end else if (previous_valid && previous_byte == preamble_value &&
                     raw_byte == start_value) begin
          phase_next       = PH_HDR;
          byte_count_next  = 8'd0;
          running_crc_next = CRC_INIT;
        end else begin
          previous_byte_next  = raw_byte;
          previous_valid_next = 1'b1;
        end
      end
      PH_HDR: begin
        running_crc_next = crc_after;
        case (byte_count[1:0])
          2'd0:    length_held_next = raw_byte;
          2'd1:    source_held_next = raw_byte;
          2'd2:    dest_held_next   = raw_byte;
          default: kind_held_next   = raw_byte;
        endcase
        if (byte_count[1:0] == 2'd0 && raw_byte > payload_limit) begin
          new_valid       = 1'b1;
          new_word.status = ST_TOOLONG;
          phase_next      = PH_SKIP;
          restart         = end_of_buffer;
        end else if (end_of_buffer) begin
          new_valid       = 1'b1;
          new_word.status = ST_TRUNC;
          restart         = 1'b1;
        end else if (byte_count[1:0] == 2'd3) begin
          byte_count_next = 8'd0;
          phase_next      = (length_held == 8'd0) ? PH_CRCH : PH_PAY;
        end else begin
          byte_count_next = count_inc;
        end
      end
      PH_PAY: begin
        if (end_of_buffer) begin
          new_valid       = 1'b1;
          new_word.status = ST_TRUNC;
          restart         = 1'b1;
        end else begin
          running_crc_next = crc_after;
          new_valid        = 1'b1;
          byte_count_next  = count_inc;
          if (count_inc >= length_held) begin
            phase_next = PH_CRCH;
          end
        end
      end
      PH_CRCH: begin
        if (end_of_buffer) begin
          new_valid       = 1'b1;
          new_word.status = ST_TRUNC;
          restart         = 1'b1;
        end else begin
          crc_high_held_next = raw_byte;
          phase_next         = PH_CRCL;
        end
      end
      PH_CRCL: begin
        new_valid       = 1'b1;
        new_word.status = ({crc_high_held, raw_byte} == running_crc) ? ST_OK : ST_BADCRC;
        phase_next      = PH_SKIP;
        restart         = end_of_buffer;
      end
      PH_SKIP: begin
        restart = end_of_buffer;
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    if (new_valid && phase == PH_PAY && !end_of_buffer) begin
      new_word.kind    = 1'b0;
      new_word.payload = raw_byte;
    end else begin
      new_word.length = length_held_next;
      new_word.source = source_held_next;
      new_word.dest   = dest_held_next;
      new_word.fkind  = kind_held_next;
    end

    if (restart) begin
      phase_next          = PH_HUNT;
      previous_byte_next  = 8'd0;
      previous_valid_next = 1'b0;
      running_crc_next    = CRC_INIT;
      length_held_next    = 8'd0;
      source_held_next    = 8'd0;
      dest_held_next      = 8'd0;
      kind_held_next      = 8'd0;
      byte_count_next     = 8'd0;
      crc_high_held_next  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      previous_byte  <= 8'd0;
      previous_valid <= 1'b0;
      running_crc    <= CRC_INIT;
      length_held    <= 8'd0;
      source_held    <= 8'd0;
      dest_held      <= 8'd0;
      kind_held      <= 8'd0;
      byte_count     <= 8'd0;
      crc_high_held  <= 8'd0;
    end else if (accept) begin
      phase          <= phase_next;
      previous_byte  <= previous_byte_next;
      previous_valid <= previous_valid_next;
      running_crc    <= running_crc_next;
      length_held    <= length_held_next;
      source_held    <= source_held_next;
      dest_held      <= dest_held_next;
      kind_held      <= kind_held_next;
      byte_count     <= byte_count_next;
      crc_high_held  <= crc_high_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= skid_valid || (accept && new_valid);
      skid_valid   <= 1'b0;
    end else if (accept && new_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      out_word <= skid_valid ? skid_word : new_word;
    end else if (accept && new_valid) begin
      skid_word <= new_word;
    end
  end

  assign result_kind  = out_word.kind;
  assign payload_byte = out_word.payload;
  assign frame_status = out_word.status;
  assign frame_length = out_word.length;
  assign source_id    = out_word.source;
  assign dest_id      = out_word.dest;
  assign frame_kind   = out_word.fkind;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid register full while output register is empty");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind) |-> (payload_byte == 8'd0 && frame_status <= ST_BADCRC))
    else $error("status word carries payload or an unknown status");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_kind) |-> (frame_status == ST_OK && frame_length == 8'd0 &&
                                        source_id == 8'd0 && dest_id == 8'd0))
    else $error("payload word carries header fields");

  a_eob_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_buffer) |=> (phase == PH_HUNT && !previous_valid))
    else $error("deframer did not restart after buffer end");

  a_payload_in_frame: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_PAY) |-> (byte_count < length_held))
    else $error("payload count ran past the frame length");

endmodule
